// File: rtl/segment_intersection_test_macros.svh
// assertion macros for the segment intersection pipeline
// expects clock and reset (synchronous, active high) in the using scope
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

// checked outside reset
`define SIT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SIT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/sit_pkg.sv
// shared types and constants for the segment intersection pipeline
// no dependencies; imported by sit_mul, sit_orient and the top level
package sit_pkg;

   localparam int COORD_W        = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int TOL_W          = 32;
   localparam logic [TOL_W-1:0] TOL_RESET = 32'd42950;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TOL = 2'd0;

   // widest operand slice fed to one hardware multiplier
   localparam int MUL_SLICE_MAX = 32;

   // register stages inside one orientation unit
   localparam int ORIENT_STAGES = 9;

   typedef enum logic [2:0] {
      OUT_DEGENERATE     = 3'd0,
      OUT_SHARED_END     = 3'd1,
      OUT_NEAR_COLLINEAR = 3'd2,
      OUT_SAME_SIDE      = 3'd3,
      OUT_SECOND_REJECT  = 3'd4,
      OUT_CROSS          = 3'd5
   } outcome_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] seg_a_start_x;
      logic signed [COORD_W-1:0] seg_a_start_y;
      logic signed [COORD_W-1:0] seg_a_end_x;
      logic signed [COORD_W-1:0] seg_a_end_y;
      logic signed [COORD_W-1:0] seg_b_start_x;
      logic signed [COORD_W-1:0] seg_b_start_y;
      logic signed [COORD_W-1:0] seg_b_end_x;
      logic signed [COORD_W-1:0] seg_b_end_y;
   } seg_pair_type;

   typedef struct packed {
      logic        intersects;
      outcome_type outcome;
   } seg_result_type;

   // orientation of one point against one segment
   typedef struct packed {
      logic near;
      logic pos;
      logic neg;
   } orient_type;

   // endpoint checks that decide before any orientation
   typedef struct packed {
      logic degenerate;
      logic shared_end;
   } early_type;

endpackage

// File: rtl/segment_intersection_test.sv
// segment crossing test, top level: request register, four sit_orient units and
// the decision/result register; uses sit_pkg, sit_orient and the assertion macros.
// an accepted request passes the request register, the sit_orient stages and the result register to rsp_data.
// throughput: one request per cycle while rsp_stall is low; stages advance independently, so bubbles close up.
// reset clears every stage valid bit and loads the tolerance with 42950.
`include "segment_intersection_test_macros.svh"

module segment_intersection_test #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sit_pkg::seg_pair_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sit_pkg::seg_result_type        rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sit_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sit_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sit_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sit_pkg::*;

   localparam int NSTAGE = ORIENT_STAGES + 2;
   localparam int TAKE_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

   function automatic logic signed [COORD_BITS-1:0] take(input logic [COORD_W-1:0] f);
      return COORD_BITS'($signed(f[TAKE_W-1:0]));
   endfunction

   logic [NSTAGE-1:0] valid_ff, valid_in, stage_en;
   logic [TOL_W-1:0]  tol_ff;
   logic              csr_wr;

   logic signed [COORD_BITS-1:0] a0x_ff, a0y_ff, a1x_ff, a1y_ff;
   logic signed [COORD_BITS-1:0] b0x_ff, b0y_ff, b1x_ff, b1y_ff;

   early_type      early_in;
   early_type      early_ff [ORIENT_STAGES];
   orient_type     o_b0, o_b1, o_a0, o_a1;
   seg_result_type result_in, rsp_ff;
   logic           rsp_flag_ok;

   // each stage moves when it is empty or the one after it moves
   always_comb begin
      stage_en[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   // configuration
   assign csr_wr = psel && penable && pwrite && (paddr == ADDR_TOL);
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_TOL) ? CSR_DATA_W'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr) begin
         tol_ff <= TOL_W'(pwdata);
      end
   end

   // stage 0: request register
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a0x_ff <= take(req_data.seg_a_start_x);
         a0y_ff <= take(req_data.seg_a_start_y);
         a1x_ff <= take(req_data.seg_a_end_x);
         a1y_ff <= take(req_data.seg_a_end_y);
         b0x_ff <= take(req_data.seg_b_start_x);
         b0y_ff <= take(req_data.seg_b_start_y);
         b1x_ff <= take(req_data.seg_b_end_x);
         b1y_ff <= take(req_data.seg_b_end_y);
      end
   end

   // endpoint checks, carried alongside the orientation units
   assign early_in.degenerate = (a0x_ff == a1x_ff && a0y_ff == a1y_ff) ||
                                (b0x_ff == b1x_ff && b0y_ff == b1y_ff);
   assign early_in.shared_end = (a0x_ff == b0x_ff && a0y_ff == b0y_ff) ||
                                (a0x_ff == b1x_ff && a0y_ff == b1y_ff) ||
                                (a1x_ff == b0x_ff && a1y_ff == b0y_ff) ||
                                (a1x_ff == b1x_ff && a1y_ff == b1y_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         early_ff[0] <= early_in;
      end
      for (int k = 1; k < ORIENT_STAGES; k++) begin
         if (stage_en[k+1]) begin
            early_ff[k] <= early_ff[k-1];
         end
      end
   end

   // b endpoints against a
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_b0 (
      .clock    (clock),
      .stage_en (stage_en[ORIENT_STAGES:1]),
      .tol      (tol_ff),
      .ux       (a0x_ff), .uy (a0y_ff),
      .vx       (a1x_ff), .vy (a1y_ff),
      .px       (b0x_ff), .py (b0y_ff),
      .res      (o_b0)
   );

   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_b1 (
      .clock    (clock),
      .stage_en (stage_en[ORIENT_STAGES:1]),
      .tol      (tol_ff),
      .ux       (a0x_ff), .uy (a0y_ff),
      .vx       (a1x_ff), .vy (a1y_ff),
      .px       (b1x_ff), .py (b1y_ff),
      .res      (o_b1)
   );

   // a endpoints against b
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_a0 (
      .clock    (clock),
      .stage_en (stage_en[ORIENT_STAGES:1]),
      .tol      (tol_ff),
      .ux       (b0x_ff), .uy (b0y_ff),
      .vx       (b1x_ff), .vy (b1y_ff),
      .px       (a0x_ff), .py (a0y_ff),
      .res      (o_a0)
   );

   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_a1 (
      .clock    (clock),
      .stage_en (stage_en[ORIENT_STAGES:1]),
      .tol      (tol_ff),
      .ux       (b0x_ff), .uy (b0y_ff),
      .vx       (b1x_ff), .vy (b1y_ff),
      .px       (a1x_ff), .py (a1y_ff),
      .res      (o_a1)
   );

   // decision, rules in priority order
   always_comb begin
      if (early_ff[ORIENT_STAGES-1].degenerate) begin
         result_in.outcome = OUT_DEGENERATE;
      end else if (early_ff[ORIENT_STAGES-1].shared_end) begin
         result_in.outcome = OUT_SHARED_END;
      end else if (o_b0.near || o_b1.near) begin
         result_in.outcome = OUT_NEAR_COLLINEAR;
      end else if ((o_b0.pos && o_b1.pos) || (o_b0.neg && o_b1.neg)) begin
         result_in.outcome = OUT_SAME_SIDE;
      end else if (o_a0.near || o_a1.near ||
                   !((o_a0.pos && o_a1.neg) || (o_a0.neg && o_a1.pos))) begin
         result_in.outcome = OUT_SECOND_REJECT;
      end else begin
         result_in.outcome = OUT_CROSS;
      end
      result_in.intersects = (result_in.outcome == OUT_NEAR_COLLINEAR) ||
                             (result_in.outcome == OUT_CROSS);
   end

   always_ff @(posedge clock) begin
      if (stage_en[NSTAGE-1]) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_data = rsp_ff;

   assign rsp_flag_ok = rsp_data.intersects == ((rsp_data.outcome == OUT_NEAR_COLLINEAR) ||
                                                (rsp_data.outcome == OUT_CROSS));

   `SIT_ASSERT(a_accept_enters, (req_valid && !req_stall) |=> valid_ff[0], "request lost")
   `SIT_ASSERT_RST(a_reset_empty, reset |=> (!rsp_valid && !req_stall), "not empty after reset")
   `SIT_ASSERT(a_tol_write, csr_wr |=> (tol_ff == $past(pwdata)), "tolerance write not taken")
   `SIT_ASSERT(a_flag_code, rsp_valid |-> rsp_flag_ok, "intersects flag disagrees with outcome")

endmodule

// File: rtl/sit_mul.sv
// two-stage unsigned multiplier: operand a is cut into slices,
// slice products registered, then shifted and summed; uses sit_pkg
module sit_mul #(
   parameter int A_W = 34,
   parameter int B_W = 34
) (
   input  logic               clock,
   input  logic               en_a,
   input  logic               en_b,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   import sit_pkg::*;

   localparam int NSLICE  = (A_W + MUL_SLICE_MAX - 1) / MUL_SLICE_MAX;
   localparam int SLICE_W = (A_W + NSLICE - 1) / NSLICE;
   localparam int PAD_W   = NSLICE * SLICE_W;
   localparam int PP_W    = SLICE_W + B_W;
   localparam int P_W     = A_W + B_W;

   logic [PAD_W-1:0] a_pad;
   logic [PP_W-1:0]  part_in [NSLICE];
   logic [PP_W-1:0]  part_ff [NSLICE];
   logic [P_W-1:0]   p_in;
   logic [P_W-1:0]   p_ff;

   assign a_pad = PAD_W'(a);

   always_comb begin
      for (int i = 0; i < NSLICE; i++) begin
         part_in[i] = PP_W'(a_pad[i*SLICE_W +: SLICE_W]) * PP_W'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         for (int i = 0; i < NSLICE; i++) begin
            part_ff[i] <= part_in[i];
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NSLICE; i++) begin
         p_in = p_in + (P_W'(part_ff[i]) << (i * SLICE_W));
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: rtl/sit_orient.sv
// orientation of point p against segment u-v: sign of the cross product and an
// exact near-zero test d^2 * 2^64 < t^2 * |u-p|^2 * |v-p|^2; uses sit_pkg, sit_mul
module sit_orient #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic [sit_pkg::ORIENT_STAGES-1:0] stage_en,
   input  logic [sit_pkg::TOL_W-1:0]         tol,
   input  logic signed [COORD_BITS-1:0]      ux,
   input  logic signed [COORD_BITS-1:0]      uy,
   input  logic signed [COORD_BITS-1:0]      vx,
   input  logic signed [COORD_BITS-1:0]      vy,
   input  logic signed [COORD_BITS-1:0]      px,
   input  logic signed [COORD_BITS-1:0]      py,
   output sit_pkg::orient_type               res
);
   import sit_pkg::*;

   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int LW   = PW;
   localparam int DDW  = PW + 1;
   localparam int MW   = PW;
   localparam int P1W  = TOL_W + LW;
   localparam int QW   = P1W + LW;
   localparam int RW   = QW + TOL_W;
   localparam int SQW  = 2 * MW;
   localparam int SIDE = 5;

   // stage 1: differences
   logic signed [DW-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   // stage 2: products
   logic signed [PW-1:0] axby_in, aybx_in, axx_in, ayy_in, bxx_in, byy_in;
   logic signed [PW-1:0] axby_ff, aybx_ff, axx_ff, ayy_ff, bxx_ff, byy_ff;
   // stage 3: determinant and squared lengths
   logic signed [DDW-1:0] d_in, d_ff, d_neg;
   logic [LW-1:0]         l1_in, l2_in, l1_ff, l2_ff;
   // stage 4: magnitude, sign, tol * l1
   logic [MW-1:0]  mag_in, mag_ff;
   logic           pos_in, neg_in;
   logic [P1W-1:0] p1_in, p1_ff;
   logic [LW-1:0]  l2_s4_ff;
   // stages 5..8
   logic [SQW-1:0] sq6, sq7_ff, sq8_ff;
   logic [QW-1:0]  q6;
   logic [RW-1:0]  r8;
   logic           pos_ff [SIDE];
   logic           neg_ff [SIDE];
   // stage 9
   orient_type     res_in, res_ff;

   assign ax_in = DW'(ux) - DW'(px);
   assign ay_in = DW'(uy) - DW'(py);
   assign bx_in = DW'(vx) - DW'(px);
   assign by_in = DW'(vy) - DW'(py);

   assign axby_in = PW'(ax_ff) * PW'(by_ff);
   assign aybx_in = PW'(ay_ff) * PW'(bx_ff);
   assign axx_in  = PW'(ax_ff) * PW'(ax_ff);
   assign ayy_in  = PW'(ay_ff) * PW'(ay_ff);
   assign bxx_in  = PW'(bx_ff) * PW'(bx_ff);
   assign byy_in  = PW'(by_ff) * PW'(by_ff);

   assign d_in  = DDW'(axby_ff) - DDW'(aybx_ff);
   assign l1_in = LW'($unsigned(axx_ff)) + LW'($unsigned(ayy_ff));
   assign l2_in = LW'($unsigned(bxx_ff)) + LW'($unsigned(byy_ff));

   assign d_neg  = -d_ff;
   assign mag_in = MW'(d_ff[DDW-1] ? d_neg : d_ff);
   assign pos_in = !d_ff[DDW-1] && (d_ff != '0);
   assign neg_in = d_ff[DDW-1];
   assign p1_in  = P1W'(tol) * P1W'(l1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
      if (stage_en[1]) begin
         axby_ff <= axby_in;
         aybx_ff <= aybx_in;
         axx_ff  <= axx_in;
         ayy_ff  <= ayy_in;
         bxx_ff  <= bxx_in;
         byy_ff  <= byy_in;
      end
      if (stage_en[2]) begin
         d_ff  <= d_in;
         l1_ff <= l1_in;
         l2_ff <= l2_in;
      end
      if (stage_en[3]) begin
         mag_ff    <= mag_in;
         p1_ff     <= p1_in;
         l2_s4_ff  <= l2_ff;
         pos_ff[0] <= pos_in;
         neg_ff[0] <= neg_in;
      end
      for (int k = 1; k < SIDE; k++) begin
         if (stage_en[3+k]) begin
            pos_ff[k] <= pos_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      if (stage_en[6]) begin
         sq7_ff <= sq6;
      end
      if (stage_en[7]) begin
         sq8_ff <= sq7_ff;
      end
      if (stage_en[8]) begin
         res_ff <= res_in;
      end
   end

   // |d|^2 and tol * l1 * l2, stages 5 and 6
   sit_mul #(.A_W(MW), .B_W(MW)) u_sq (
      .clock (clock),
      .en_a  (stage_en[4]),
      .en_b  (stage_en[5]),
      .a     (mag_ff),
      .b     (mag_ff),
      .p     (sq6)
   );

   sit_mul #(.A_W(P1W), .B_W(LW)) u_q (
      .clock (clock),
      .en_a  (stage_en[4]),
      .en_b  (stage_en[5]),
      .a     (p1_ff),
      .b     (l2_s4_ff),
      .p     (q6)
   );

   // second factor of tol, stages 7 and 8
   sit_mul #(.A_W(QW), .B_W(TOL_W)) u_r (
      .clock (clock),
      .en_a  (stage_en[6]),
      .en_b  (stage_en[7]),
      .a     (q6),
      .b     (tol),
      .p     (r8)
   );

   // the 2^64 scale on the left lines up with the q0.32 tolerance squared
   assign res_in.near = {sq8_ff, {(2*TOL_W){1'b0}}} < r8;
   assign res_in.pos  = pos_ff[SIDE-1];
   assign res_in.neg  = neg_ff[SIDE-1];

   assign res = res_ff;

endmodule

// File: bench/testbench.sv
// self-checking bench for the segment crossing pipeline (segment_intersection_test)
// predicts each result from the tolerance and the request, checks results in order
// depends on sit_pkg and the rtl top level only
`timescale 1ns / 1ps

module testbench;
   import sit_pkg::*;

   localparam int PIPE_LATENCY        = 10;
   localparam int BACKPRESSURE_CYCLES = 80;
   localparam longint TIMEOUT_NS      = 2_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   seg_pair_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   seg_result_type        rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [TOL_W-1:0] tolerance_setting = TOL_RESET;
   seg_result_type   expected_results[$];
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   bit               hold_request = 1'b0;
   int               hold_left = 0;

   segment_intersection_test dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // orientation of point p against segment u-v, with the exact near-zero test
   function automatic void orient_test(input longint ux, uy, vx, vy, px, py,
                                       input logic [TOL_W-1:0] tol,
                                       output int sgn, output bit is_near);
      longint     ax, ay, bx, by, d;
      bit [63:0]  mag, l1, l2;
      bit [255:0] lhs, rhs;
      ax = ux - px;
      ay = uy - py;
      bx = vx - px;
      by = vy - py;
      d = ax * by - ay * bx;
      mag = (d < 0) ? -d : d;
      l1 = ax * ax + ay * ay;
      l2 = bx * bx + by * by;
      sgn = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      lhs = ({192'd0, mag} * {192'd0, mag}) << 64;
      rhs = {224'd0, tol} * {224'd0, tol} * {192'd0, l1} * {192'd0, l2};
      is_near = lhs < rhs;
   endfunction

   function automatic seg_result_type classify_pair(input seg_pair_type p,
                                                    input logic [TOL_W-1:0] tol);
      longint         a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
      int             s1, s2, s3, s4;
      bit             n1, n2, n3, n4;
      outcome_type    code;
      seg_result_type res;
      a0x = p.seg_a_start_x;
      a0y = p.seg_a_start_y;
      a1x = p.seg_a_end_x;
      a1y = p.seg_a_end_y;
      b0x = p.seg_b_start_x;
      b0y = p.seg_b_start_y;
      b1x = p.seg_b_end_x;
      b1y = p.seg_b_end_y;
      if ((a0x == a1x && a0y == a1y) || (b0x == b1x && b0y == b1y)) begin
         code = OUT_DEGENERATE;
      end else if ((a0x == b0x && a0y == b0y) || (a0x == b1x && a0y == b1y) ||
                   (a1x == b0x && a1y == b0y) || (a1x == b1x && a1y == b1y)) begin
         code = OUT_SHARED_END;
      end else begin
         orient_test(a0x, a0y, a1x, a1y, b0x, b0y, tol, s1, n1);
         orient_test(a0x, a0y, a1x, a1y, b1x, b1y, tol, s2, n2);
         if (n1 || n2) begin
            code = OUT_NEAR_COLLINEAR;
         end else if (s1 * s2 > 0) begin
            code = OUT_SAME_SIDE;
         end else begin
            orient_test(b0x, b0y, b1x, b1y, a0x, a0y, tol, s3, n3);
            orient_test(b0x, b0y, b1x, b1y, a1x, a1y, tol, s4, n4);
            code = (n3 || n4 || s3 * s4 >= 0) ? OUT_SECOND_REJECT : OUT_CROSS;
         end
      end
      res.outcome = code;
      res.intersects = (code == OUT_NEAR_COLLINEAR || code == OUT_CROSS);
      return res;
   endfunction

   function automatic longint pick(input longint lo, input longint hi);
      return lo + longint'($urandom_range(int'(hi - lo)));
   endfunction

   function automatic seg_pair_type random_pair();
      longint c[8];
      longint cx, cy, ux, uy, wx, wy, sx, sy, dx, dy, num;
      int     kind;
      kind = $urandom_range(9);
      case (kind)
         0: begin
            foreach (c[i]) c[i] = pick(-32768, 32767);
         end
         1: begin
            // tiny grid: lots of degenerate, shared-end and collinear pairs
            foreach (c[i]) c[i] = pick(-4, 4);
         end
         2, 3: begin
            // B points near the line through A
            c[0] = pick(-8000, 8000);
            c[1] = pick(-8000, 8000);
            c[2] = pick(-8000, 8000);
            c[3] = pick(-8000, 8000);
            dx = c[2] - c[0];
            dy = c[3] - c[1];
            for (int i = 4; i < 8; i += 2) begin
               num = pick(-4, 12);
               c[i]   = c[0] + dx * num / 8 + pick(-3, 3);
               c[i+1] = c[1] + dy * num / 8 + pick(-3, 3);
            end
         end
         4, 5, 6: begin
            // two segments around a common center, sometimes pulled apart
            cx = pick(-10000, 10000);
            cy = pick(-10000, 10000);
            ux = pick(-10000, 10000);
            uy = pick(-10000, 10000);
            wx = pick(-10000, 10000);
            wy = pick(-10000, 10000);
            sx = $urandom_range(1) ? pick(-3000, 3000) : 0;
            sy = $urandom_range(1) ? pick(-3000, 3000) : 0;
            num = pick(1, 4);
            c[0] = cx + ux;
            c[1] = cy + uy;
            c[2] = cx - ux * num / 4;
            c[3] = cy - uy * num / 4;
            c[4] = cx + wx + sx;
            c[5] = cy + wy + sy;
            c[6] = cx - wx + sx;
            c[7] = cy - wy + sy;
         end
         7: begin
            foreach (c[i]) begin
               case ($urandom_range(4))
                  0: c[i] = -32768;
                  1: c[i] = 32767;
                  2: c[i] = 0;
                  3: c[i] = -1;
                  default: c[i] = pick(-32768, 32767);
               endcase
            end
         end
         default: begin
            foreach (c[i]) c[i] = pick(-200, 200);
         end
      endcase
      return {c[0][15:0], c[1][15:0], c[2][15:0], c[3][15:0],
              c[4][15:0], c[5][15:0], c[6][15:0], c[7][15:0]};
   endfunction

   // called at a falling edge, returns at a falling edge after acceptance
   task automatic send_pair(input seg_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(classify_pair(p, tolerance_setting));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_coords(input longint a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y);
      send_pair({a0x[15:0], a0y[15:0], a1x[15:0], a1y[15:0],
                 b0x[15:0], b0y[15:0], b1x[15:0], b1y[15:0]});
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_pair(random_pair());
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
      @(negedge clock);
   endtask

   // write the tolerance register, then read it back
   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      wait_idle();
      paddr = ADDR_TOL;
      pwdata = value;
      pwrite = 1'b1;
      psel = 1'b1;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tolerance_setting = value;
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      if (readback !== value) begin
         $display("%0t: tolerance readback mismatch: expected %h, actual %h",
                  $time, value, readback);
         error_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_coords(5, 5, 5, 5, 0, 0, 10, 10);
      send_coords(0, 0, 10, 0, 3, 3, 3, 3);
      send_coords(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
      send_coords(0, 0, 10, 10, 0, 0, 10, -10);
      send_coords(0, 0, 10, 10, 5, -5, 0, 0);
      send_coords(0, 0, 10, 10, 10, 10, 20, 0);
      send_coords(-32768, 32767, 32767, -32768, 0, 0, 32767, -32768);
      // t junction and collinear overlap
      send_coords(0, 0, 20, 0, 10, 0, 10, 10);
      send_coords(0, 0, 20, 0, 10, 0, 30, 0);
      send_coords(-30000, 0, 30000, 1, -29000, 5, 29000, -5);
      send_coords(-32768, 0, 32767, 0, -32768, 1, 32767, -1);
      send_coords(0, 0, 10, 0, 0, 5, 10, 8);
      send_coords(0, 0, 10, 0, 20, -5, 20, 5);
      // endpoint of A touching the inside of B
      send_coords(5, 0, 20, 3, 5, -5, 5, 5);
      send_coords(0, 0, 10, 10, 0, 10, 10, 0);
      send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(-1, -1, 32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(230);
   endtask

   task automatic test_sender_idle();
      write_tolerance(32'd1);
      send_idle_pct = 49;
      recv_stall_pct = 0;
      send_random(180);
   endtask

   task automatic test_receiver_stall();
      write_tolerance(32'h0100_0000);
      send_idle_pct = 0;
      recv_stall_pct = 49;
      send_random(180);
   endtask

   task automatic test_zero_tolerance();
      write_tolerance(32'd0);
      send_idle_pct = 35;
      recv_stall_pct = 35;
      send_coords(0, 0, 20, 0, 10, 0, 30, 0);
      send_coords(0, 0, 20, 0, 10, 0, 10, 10);
      send_random(150);
   endtask

   task automatic test_full_tolerance();
      write_tolerance(32'hFFFF_FFFF);
      send_idle_pct = 35;
      recv_stall_pct = 35;
      send_random(150);
   endtask

   // receiver holds off long enough for the pipeline to fill and stall requests
   task automatic test_backpressure();
      write_tolerance(TOL_RESET);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      send_random(60);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = BACKPRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      seg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: intersects=%0b outcome=%0d",
                     $time, rsp_data.intersects, rsp_data.outcome);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.intersects !== want.intersects ||
                rsp_data.outcome !== want.outcome) begin
               $display("%0t: result mismatch: expected intersects=%0b outcome=%0d, %s",
                        $time, want.intersects, want.outcome,
                        $sformatf("actual intersects=%0b outcome=%0d",
                                  rsp_data.intersects, rsp_data.outcome));
               error_count++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_zero_tolerance();
      test_full_tolerance();
      test_backpressure();
      wait_idle();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
